// File: rtl/rq_pkg.sv
// Shared types and codes for the scheduler ready queue.
// Used by rq_ctrl, rq_datapath and the top level ready_queue_fifo_or_priority.
package rq_pkg;

  localparam int unsigned IdW   = 8;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 5;

  localparam logic       ACT_ENQ   = 1'b0;
  localparam logic       ACT_DEQ   = 1'b1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load_req;
    logic    fail;
    status_e fail_code;
    logic    append;
    logic    walk_start;
    logic    walk_step;
    logic    deq_pop;
    logic    load_out;
  } rq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic req_deq;
    logic mode_prio;
    logic walk_end;
    logic out_free;
  } rq_stat_t;

endpackage

// File: rtl/rq_datapath.sv
// Datapath of the ready queue: entry memory (circular buffer), pointers,
// request and result registers, output register. Depends on rq_pkg.
module rq_datapath import rq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               action_i,
  input  logic [IdW-1:0]     thread_id_i,
  input  logic [PrioW-1:0]   priority_req_i,
  input  logic               out_stall_i,
  input  rq_cmd_t            cmd_i,
  output rq_stat_t           stat_o,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [IdW-1:0]     out_thread_id_o,
  output logic [PrioW-1:0]   out_priority_o,
  output logic [OccW-1:0]    occupancy_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DepthW = (IW + 1)'(DEPTH);
  localparam logic [IW:0]   OneW   = (IW + 1)'(1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  logic [1:0]    mode_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [IW-1:0] ptr_q;
  logic [CW-1:0] off_q;
  logic          found_q;
  entry_t        carry_q;
  logic          req_deq_q;
  entry_t        req_q;
  status_e       res_status_q;
  logic [IdW-1:0]   res_id_q;
  logic [PrioW-1:0] res_prio_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [IdW-1:0]   out_id_q;
  logic [PrioW-1:0] out_prio_q;
  logic [OccW-1:0]  out_occ_q;

  logic [IW:0]   ptr_sum, head_sum, tail_sum;
  logic [IW-1:0] ptr_nxt, head_nxt, tail_addr;
  logic          at_end, take, wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  entry_t        wr_data;

  // Circular index arithmetic: every sum stays below twice the depth.
  always_comb begin
    ptr_sum   = {1'b0, ptr_q} + OneW;
    ptr_nxt   = (ptr_sum >= DepthW) ? IW'(ptr_sum - DepthW) : ptr_sum[IW-1:0];
    head_sum  = {1'b0, head_q} + OneW;
    head_nxt  = (head_sum >= DepthW) ? IW'(head_sum - DepthW) : head_sum[IW-1:0];
    tail_sum  = {1'b0, head_q} + (IW + 1)'(count_q);
    tail_addr = (tail_sum >= DepthW) ? IW'(tail_sum - DepthW) : tail_sum[IW-1:0];
  end

  // Walk: drop the new entry at the first slot whose priority is not less,
  // then ripple each displaced entry one slot toward the tail.
  assign at_end  = (off_q == count_q);
  assign take    = found_q | at_end | (rdata_q.prio >= req_q.prio);
  assign wr_en   = cmd_i.append | (cmd_i.walk_step & take);
  assign wr_addr = cmd_i.append ? tail_addr : ptr_q;
  assign wr_data = cmd_i.append ? req_q : carry_q;
  // Head is read by default, which primes both dequeue and walk.
  assign rd_addr = cmd_i.walk_step ? ptr_nxt : head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.append || (cmd_i.walk_step && at_end)) begin
        count_q <= count_q + OneC;
      end else if (cmd_i.deq_pop) begin
        count_q <= count_q - OneC;
      end
      if (cmd_i.deq_pop) begin
        head_q <= head_nxt;
      end
      if (cmd_i.walk_start) begin
        found_q <= 1'b0;
      end else if (cmd_i.walk_step && take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_deq_q    <= (action_i == ACT_DEQ);
      req_q.id     <= thread_id_i;
      req_q.prio   <= priority_req_i;
      res_status_q <= STAT_DONE;
      res_id_q     <= '0;
      res_prio_q   <= '0;
    end
    if (cmd_i.fail) begin
      res_status_q <= cmd_i.fail_code;
    end
    if (cmd_i.deq_pop) begin
      res_id_q   <= rdata_q.id;
      res_prio_q <= rdata_q.prio;
    end
    if (cmd_i.walk_start) begin
      ptr_q   <= head_q;
      off_q   <= '0;
      carry_q <= req_q;
    end else if (cmd_i.walk_step) begin
      ptr_q <= ptr_nxt;
      off_q <= off_q + OneC;
      if (take) begin
        carry_q <= rdata_q;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_prio_q   <= res_prio_q;
      out_occ_q    <= OccW'(count_q);
    end
  end

  always_comb begin
    stat_o.is_empty  = (count_q == '0);
    stat_o.is_full   = (count_q == DepthC);
    stat_o.req_deq   = req_deq_q;
    stat_o.mode_prio = (mode_q == MODE_PRIO);
    stat_o.walk_end  = at_end;
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_thread_id_o = out_id_q;
  assign out_priority_o  = out_prio_q;
  assign occupancy_o     = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("entry count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deq_pop |-> count_q != '0) else $error("pop from empty queue");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> off_q <= count_q) else $error("walk ran past tail");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append || cmd_i.walk_start) |-> count_q != DepthC)
    else $error("insert into full queue");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

// File: rtl/rq_ctrl.sv
// Request sequencer of the ready queue: one-hot state machine issuing
// datapath commands. Depends on rq_pkg.
module rq_ctrl import rq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  rq_stat_t stat_i,
  output rq_cmd_t  cmd_o,
  output logic     in_stall_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_DEQ      = 5'b00100,
    S_WALK     = 5'b01000,
    S_FINISH   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.req_deq) begin
          if (stat_i.is_empty) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = STAT_EMPTY;
            state_d         = S_FINISH;
          end else begin
            state_d = S_DEQ;
          end
        end else if (stat_i.is_full) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = STAT_FULL;
          state_d         = S_FINISH;
        end else if (stat_i.mode_prio) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_DEQ: begin
        cmd_o.deq_pop = 1'b1;
        state_d       = S_FINISH;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_DISPATCH)
    else $error("accepted beat not dispatched");

  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && stat_i.walk_end) |=> state_q == S_FINISH)
    else $error("walk did not finish at tail");

  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && stat_i.out_free) |-> cmd_o.load_out)
    else $error("finished result not loaded");

endmodule

// File: rtl/ready_queue_fifo_or_priority.sv
// Top level of the scheduler ready queue: controller plus datapath.
// Depends on rq_pkg, rq_ctrl and rq_datapath.
//
// Ready queue holding up to DEPTH entries of (thread id, priority). One
// request beat is taken at a time and each yields exactly one result beat.
// Modes 0, 1 and the unused code 3 append at the tail; mode 2 inserts the
// entry before the first stored entry whose priority is not less than its
// own, so lower values are served first and a newcomer goes ahead of equal
// priorities. A dequeue removes the head. Status reports an empty queue on
// dequeue and a full queue on enqueue (the entry is dropped); id and
// priority fields are zero unless a dequeue succeeded. Occupancy is the
// entry count after the request, kept to 5 bits. Entries live in a
// single-port-write, registered-read memory used as a circular buffer, so
// dequeue and tail append need no walk over the stored entries, while a
// priority insert walks from the head to the tail, moving one entry per
// cycle through the memory's single read and write port. A new request
// is taken once the previous one has been placed in the output register;
// a stalled result holds in that register while the next request is
// taken, and the next result waits until the held one is taken. The
// user must see that the mode register is written by cfg_we_i /
// cfg_wdata_i only while the block is idle; the block itself does not
// enforce this. No clearing pass is needed after reset.
module ready_queue_fifo_or_priority import rq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [IdW-1:0]   thread_id_i,
  input  logic [PrioW-1:0] priority_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [IdW-1:0]   out_thread_id_o,
  output logic [PrioW-1:0] out_priority_o,
  output logic [OccW-1:0]  occupancy_o
);

  rq_cmd_t  cmd;
  rq_stat_t stat;

  // Sequencer: accept, dispatch, walk or pop, then hand off the result.
  rq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Storage, pointers, mode register and the output register.
  rq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .thread_id_i     (thread_id_i),
    .priority_req_i  (priority_req_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .out_thread_id_o (out_thread_id_o),
    .out_priority_o  (out_priority_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
